// ===== hdl/pcp_pkg.sv =====
// shared types and constants for the protection command port
`timescale 1ns / 1ps

package pcp_pkg;

    localparam int RAM_DEPTH = 128;
    localparam int RAM_AW    = 7;
    localparam int SEQ_MAX   = 8;
    localparam int SEQ_LW    = 4;

    // port access codes
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_STATUS = 2'd2;

    // error codes on a data write
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_INDEX   = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;
    localparam logic [1:0] ERR_PREFIX  = 2'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_DIP_ONE = 8'd0;
    localparam logic [7:0] CFG_DIP_TWO = 8'd1;

    localparam logic [7:0] DIP_ONE_RESET = 8'hfb;
    localparam logic [7:0] DIP_TWO_RESET = 8'hff;

    // command bytes
    localparam logic [7:0] CMD_PREFIX    = 8'h00;
    localparam logic [7:0] CMD_STATE     = 8'h01;
    localparam logic [7:0] CMD_CREDIT_A  = 8'h02;
    localparam logic [7:0] CMD_WRITE_RAM = 8'h03;
    localparam logic [7:0] CMD_BLOCK_7   = 8'h04;
    localparam logic [7:0] CMD_PLAYERS   = 8'h05;
    localparam logic [7:0] CMD_CREDIT_B  = 8'h07;
    localparam logic [7:0] CMD_FULL      = 8'h08;
    localparam logic [7:0] CMD_BLOCK_6   = 8'h09;
    localparam logic [7:0] CMD_CREDIT_C  = 8'h0a;
    localparam logic [7:0] CMD_CREDIT_I1 = 8'h0c;
    localparam logic [7:0] CMD_CREDIT_I2 = 8'h0d;
    localparam logic [7:0] CMD_TOGGLE    = 8'hfe;
    localparam logic [7:0] CMD_WRITEBACK = 8'hff;
    localparam logic [7:0] CMD_NOP_0     = 8'h92;
    localparam logic [7:0] CMD_NOP_1     = 8'h97;
    localparam logic [7:0] CMD_NOP_2     = 8'h9a;
    localparam logic [7:0] CMD_NOP_3     = 8'ha3;
    localparam logic [7:0] CMD_NOP_4     = 8'ha5;
    localparam logic [7:0] CMD_NOP_5     = 8'ha9;
    localparam logic [7:0] CMD_NOP_6     = 8'had;
    localparam logic [7:0] CMD_NOP_7     = 8'hb0;
    localparam logic [7:0] CMD_NOP_8     = 8'hb3;
    localparam logic [7:0] CMD_NOP_9     = 8'hb7;

    localparam logic [7:0] STATE_BYTE = 8'h82;
    localparam logic [7:0] CREDITS    = 8'h01;
    localparam logic [RAM_AW-1:0] PARAM_COUNT = 7'd8;

    localparam logic [3:0] STATUS_BUSY  = 4'b1000;
    localparam logic [3:0] STATUS_EMPTY = 4'b0100;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] write_data;
        logic [7:0] coin_start_bits;
        logic [7:0] player_one_bits;
        logic [7:0] player_two_bits;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] status_bits;
        logic [1:0] error_code;
    } out_item_t;

    typedef struct packed {
        logic                          en;
        logic [SEQ_LW-1:0]             start;
        logic [SEQ_LW-1:0]             len;
        logic [SEQ_MAX-1:0][7:0]       bytes;
    } push_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

endpackage

// ===== hdl/pcp_ram.sv =====
// device ram with per-entry valid bits and a registered read port
`timescale 1ns / 1ps

module pcp_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pcp_pkg::ram_wr_t           wr,
    input  logic [pcp_pkg::RAM_AW-1:0] rd_addr,
    output logic [7:0]                 rd_data
);

    logic [7:0]                     mem [pcp_pkg::RAM_DEPTH];
    logic [pcp_pkg::RAM_DEPTH-1:0]  valid_reg;
    logic [7:0]                     raw_reg;
    logic                           hit_reg;
    logic                           fwd_reg;
    logic [7:0]                     fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        raw_reg      <= mem[rd_addr];
        fwd_data_reg <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            hit_reg <= valid_reg[rd_addr];
            // write to the address being read this cycle
            fwd_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    // entries never written read as zero
    assign rd_data = fwd_reg ? fwd_data_reg : (hit_reg ? raw_reg : 8'h00);

endmodule

// ===== hdl/pcp_queue.sv =====
// output byte queue: head pops with a shift, commands write fixed positions
`timescale 1ns / 1ps

module pcp_queue #(
    parameter int OUT_DEPTH = 8,
    parameter int CW        = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pcp_pkg::push_t push,
    input  logic           pop,
    output logic [CW-1:0]  count,
    output logic [7:0]     head
);

    logic [7:0]    q_reg  [OUT_DEPTH];
    logic [7:0]    q_next [OUT_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb
    begin
        int rel;
        for (int i = 0; i < OUT_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
            if (pop && (i < OUT_DEPTH - 1))
            begin
                q_next[i] = q_reg[(i + 1) % OUT_DEPTH];
            end
            rel = i - int'(push.start);
            if (push.en && (rel >= 0) && (rel < int'(push.len)))
            begin
                q_next[i] = push.bytes[rel[2:0]];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (push.en)
        begin
            count_next = CW'(push.start) + CW'(push.len);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < OUT_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;
    assign head  = q_reg[0];

endmodule

// ===== hdl/pcp_core.sv =====
// command decode, mode/offset/busy state and dip switch registers
`timescale 1ns / 1ps

module pcp_core #(
    parameter int CW = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  pcp_pkg::in_item_t          item,
    input  logic [CW-1:0]              count,
    input  logic [7:0]                 head,
    input  logic [7:0]                 ram_data,
    input  logic                       cfg_valid,
    input  logic [7:0]                 cfg_index,
    input  logic [7:0]                 cfg_data,
    output pcp_pkg::out_item_t         result,
    output pcp_pkg::push_t             push,
    output logic                       pop,
    output pcp_pkg::ram_wr_t           ram_wr,
    output logic [pcp_pkg::RAM_AW-1:0] rd_addr
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_WBYTES = 3'd1,
        MODE_WBYTE  = 3'd2,
        MODE_RBYTES = 3'd3,
        MODE_WAIT1  = 3'd4,
        MODE_WAIT2  = 3'd5,
        MODE_PARAM  = 3'd6
    } mode_t;

    mode_t                       mode_reg;
    mode_t                       mode_next;
    logic [pcp_pkg::RAM_AW-1:0]  offset_reg;
    logic [pcp_pkg::RAM_AW-1:0]  offset_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic [7:0]                  dip_one_reg;
    logic [7:0]                  dip_two_reg;
    logic                        at0;
    logic                        at1;
    logic                        at2;
    logic [7:0]                  cs;

    assign at0 = (count == CW'(0));
    assign at1 = (count == CW'(1));
    assign at2 = (count == CW'(2));
    assign cs  = item.coin_start_bits;

    always_comb
    begin
        mode_next   = mode_reg;
        offset_next = offset_reg;
        busy_next   = busy_reg;
        result      = '0;
        push        = '0;
        pop         = 1'b0;
        ram_wr.en   = 1'b0;
        ram_wr.addr = offset_reg;
        ram_wr.data = item.write_data;
        if (advance)
        begin
            unique case (item.func)
                pcp_pkg::FUNC_WRITE:
                begin
                    busy_next = 1'b1;
                    unique case (mode_reg)
                        MODE_WAIT1:
                        begin
                            if (at0)
                            begin
                                push.en       = 1'b1;
                                push.len      = 4'd1;
                                push.bytes[0] = dip_two_reg;
                                mode_next     = MODE_WAIT2;
                            end
                            else
                            begin
                                result.error_code = pcp_pkg::ERR_INDEX;
                            end
                        end
                        MODE_WAIT2:
                        begin
                            mode_next   = MODE_PARAM;
                            offset_next = '0;
                        end
                        MODE_PARAM:
                        begin
                            offset_next = offset_reg + 7'd1;
                            if (offset_next == pcp_pkg::PARAM_COUNT)
                            begin
                                mode_next = MODE_NORMAL;
                            end
                        end
                        MODE_WBYTE:
                        begin
                            ram_wr.en   = 1'b1;
                            offset_next = offset_reg + 7'd1;
                            mode_next   = MODE_WBYTES;
                        end
                        default:
                        begin
                            case (item.write_data) inside
                                pcp_pkg::CMD_PREFIX:
                                begin
                                    if (mode_reg == MODE_WBYTES)
                                    begin
                                        mode_next = MODE_WBYTE;
                                    end
                                    else if (mode_reg == MODE_RBYTES)
                                    begin
                                        if (at0)
                                        begin
                                            push.en       = 1'b1;
                                            push.len      = 4'd1;
                                            push.bytes[0] = ram_data;
                                            offset_next   = offset_reg + 7'd1;
                                        end
                                        else
                                        begin
                                            result.error_code = pcp_pkg::ERR_INDEX;
                                        end
                                    end
                                    else
                                    begin
                                        result.error_code = pcp_pkg::ERR_PREFIX;
                                    end
                                end
                                pcp_pkg::CMD_STATE:
                                begin
                                    push.en       = at0;
                                    push.len      = 4'd1;
                                    push.bytes[0] = pcp_pkg::STATE_BYTE;
                                end
                                pcp_pkg::CMD_CREDIT_A, pcp_pkg::CMD_CREDIT_B,
                                pcp_pkg::CMD_CREDIT_C:
                                begin
                                    push.en       = at0;
                                    push.len      = 4'd3;
                                    push.bytes[0] = pcp_pkg::CREDITS;
                                    push.bytes[1] = cs;
                                    push.bytes[2] = pcp_pkg::STATE_BYTE;
                                end
                                pcp_pkg::CMD_CREDIT_I1:
                                begin
                                    push.en       = at1;
                                    push.start    = 4'd1;
                                    push.len      = 4'd3;
                                    push.bytes[0] = pcp_pkg::CREDITS;
                                    push.bytes[1] = cs;
                                    push.bytes[2] = pcp_pkg::STATE_BYTE;
                                end
                                pcp_pkg::CMD_CREDIT_I2:
                                begin
                                    push.en       = at2;
                                    push.start    = 4'd2;
                                    push.len      = 4'd3;
                                    push.bytes[0] = pcp_pkg::CREDITS;
                                    push.bytes[1] = cs;
                                    push.bytes[2] = pcp_pkg::STATE_BYTE;
                                end
                                pcp_pkg::CMD_WRITE_RAM:
                                begin
                                    mode_next   = MODE_WBYTES;
                                    offset_next = '0;
                                end
                                pcp_pkg::CMD_BLOCK_7:
                                begin
                                    push.en       = at0;
                                    push.len      = 4'd7;
                                    push.bytes[4] = pcp_pkg::CREDITS;
                                    push.bytes[5] = cs;
                                    push.bytes[6] = pcp_pkg::STATE_BYTE;
                                end
                                pcp_pkg::CMD_PLAYERS:
                                begin
                                    push.en       = at0;
                                    push.len      = 4'd8;
                                    push.bytes[0] = item.player_one_bits;
                                    push.bytes[2] = item.player_two_bits;
                                    push.bytes[5] = pcp_pkg::CREDITS;
                                    push.bytes[6] = cs;
                                    push.bytes[7] = pcp_pkg::STATE_BYTE;
                                end
                                pcp_pkg::CMD_FULL:
                                begin
                                    push.en       = at0;
                                    push.len      = 4'd8;
                                    push.bytes[0] = cs;
                                    push.bytes[1] = item.player_one_bits;
                                    push.bytes[2] = item.player_two_bits;
                                    push.bytes[3] = dip_one_reg;
                                    push.bytes[4] = dip_two_reg;
                                    push.bytes[5] = pcp_pkg::CREDITS;
                                    push.bytes[6] = cs;
                                    push.bytes[7] = pcp_pkg::STATE_BYTE;
                                end
                                pcp_pkg::CMD_BLOCK_6:
                                begin
                                    push.en       = at0;
                                    push.len      = 4'd6;
                                    push.bytes[3] = pcp_pkg::CREDITS;
                                    push.bytes[4] = cs;
                                    push.bytes[5] = pcp_pkg::STATE_BYTE;
                                end
                                pcp_pkg::CMD_TOGGLE:
                                begin
                                    mode_next   = (mode_reg == MODE_WBYTES) ? MODE_RBYTES
                                                                            : MODE_WBYTES;
                                    offset_next = '0;
                                end
                                pcp_pkg::CMD_WRITEBACK:
                                begin
                                    push.en       = at0;
                                    push.len      = 4'd1;
                                    push.bytes[0] = dip_one_reg;
                                    if (at0)
                                    begin
                                        mode_next = MODE_WAIT1;
                                    end
                                end
                                pcp_pkg::CMD_NOP_0, pcp_pkg::CMD_NOP_1, pcp_pkg::CMD_NOP_2,
                                pcp_pkg::CMD_NOP_3, pcp_pkg::CMD_NOP_4, pcp_pkg::CMD_NOP_5,
                                pcp_pkg::CMD_NOP_6, pcp_pkg::CMD_NOP_7, pcp_pkg::CMD_NOP_8,
                                pcp_pkg::CMD_NOP_9:
                                begin
                                end
                                default:
                                begin
                                    result.error_code = pcp_pkg::ERR_UNKNOWN;
                                end
                            endcase
                            // a sequence that does not fit its start index is dropped
                            if ((push.len != '0) && !push.en &&
                                (item.write_data != pcp_pkg::CMD_PREFIX))
                            begin
                                result.error_code = pcp_pkg::ERR_INDEX;
                            end
                        end
                    endcase
                end
                pcp_pkg::FUNC_READ:
                begin
                    if (!at0)
                    begin
                        pop              = 1'b1;
                        result.read_data = head;
                    end
                end
                pcp_pkg::FUNC_STATUS:
                begin
                    busy_next = 1'b0;
                    if (busy_reg)
                    begin
                        result.status_bits = result.status_bits | pcp_pkg::STATUS_BUSY;
                    end
                    if (at0)
                    begin
                        result.status_bits = result.status_bits | pcp_pkg::STATUS_EMPTY;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rd_addr = offset_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            offset_reg  <= '0;
            busy_reg    <= 1'b0;
            dip_one_reg <= pcp_pkg::DIP_ONE_RESET;
            dip_two_reg <= pcp_pkg::DIP_TWO_RESET;
        end
        else
        begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            busy_reg   <= busy_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pcp_pkg::CFG_DIP_ONE: dip_one_reg <= cfg_data;
                    pcp_pkg::CFG_DIP_TWO: dip_two_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/protection_command_port.sv =====
// top level of the protection command port
`timescale 1ns / 1ps

// Protection command port. Each transfer on the input channel is one CPU
// access (data write, data read or status read) and gives exactly one result
// transfer. The block takes one access per clock while the result is not
// stalled; an access passes an input register and the decode/queue update
// into the result register. The device ram is zero after reset through
// per-entry valid bits, so no clearing pass is needed and the block is ready
// as soon as reset is released. The ram read for the read bytes prefix comes
// from a registered read at the current offset. Configuration writes (dip
// switch banks, index 0 and 1) are always ready.

module protection_command_port #(
    parameter int OUT_DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pcp_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pcp_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic                       in_valid_reg;
    pcp_pkg::in_item_t          in_item_reg;
    logic                       out_valid_reg;
    pcp_pkg::out_item_t         out_item_reg;
    logic                       advance;
    pcp_pkg::out_item_t         result;
    pcp_pkg::push_t             push;
    logic                       pop;
    pcp_pkg::ram_wr_t           ram_wr;
    logic [pcp_pkg::RAM_AW-1:0] rd_addr;
    logic [7:0]                 ram_data;
    logic [CW-1:0]              count;
    logic [7:0]                 head;

    // item in the input register moves on when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    pcp_core #(
        .CW (CW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (in_item_reg),
        .count     (count),
        .head      (head),
        .ram_data  (ram_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .push      (push),
        .pop       (pop),
        .ram_wr    (ram_wr),
        .rd_addr   (rd_addr)
    );

    pcp_queue #(
        .OUT_DEPTH (OUT_DEPTH),
        .CW        (CW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .count (count),
        .head  (head)
    );

    pcp_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ram_wr),
        .rd_addr (rd_addr),
        .rd_data (ram_data)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule
